// File: rtl/core/ezrm_pkg.sv
// constants, types and helpers for the euler xyz to rotation matrix core
// depends on nothing
package ezrm_pkg;

	localparam int AngleBits   = 16;
	localparam int FracBits    = 16;
	localparam int OutBits     = FracBits + 2;
	localparam int CordicSteps = 30;
	localparam int CordicW     = 34;
	localparam int PhaseW      = 33;
	localparam int ProdW       = 2 * OutBits;

	localparam logic signed [CordicW-1:0] GainInit = 34'sd652032874;

	typedef logic signed [CordicW-1:0] cval_t;
	typedef logic signed [PhaseW-1:0] phase_t;
	typedef logic signed [OutBits-1:0] fix_t;
	typedef logic signed [ProdW-1:0] prod_t;

	typedef struct packed {
		cval_t x;
		cval_t y;
		phase_t z;
		logic flip;
	} cordic_t;

	function automatic phase_t arc(input int i);
		case (i)
			0: arc = 33'sd536870912;
			1: arc = 33'sd316933406;
			2: arc = 33'sd167458907;
			3: arc = 33'sd85004756;
			4: arc = 33'sd42667331;
			5: arc = 33'sd21354465;
			6: arc = 33'sd10679838;
			7: arc = 33'sd5340245;
			8: arc = 33'sd2670163;
			9: arc = 33'sd1335087;
			10: arc = 33'sd667544;
			11: arc = 33'sd333772;
			12: arc = 33'sd166886;
			13: arc = 33'sd83443;
			14: arc = 33'sd41722;
			15: arc = 33'sd20861;
			16: arc = 33'sd10430;
			17: arc = 33'sd5215;
			18: arc = 33'sd2608;
			19: arc = 33'sd1304;
			20: arc = 33'sd652;
			21: arc = 33'sd326;
			22: arc = 33'sd163;
			23: arc = 33'sd81;
			24: arc = 33'sd41;
			25: arc = 33'sd20;
			26: arc = 33'sd10;
			27: arc = 33'sd5;
			28: arc = 33'sd3;
			29: arc = 33'sd1;
			default: arc = '0;
		endcase
	endfunction

	function automatic fix_t clamp_one(input logic signed [CordicW-1:0] v);
		logic signed [CordicW-1:0] one;
		one = cval_t'(1) <<< FracBits;
		if (v > one)
			clamp_one = fix_t'(one);
		else if (v < -one)
			clamp_one = fix_t'(-one);
		else
			clamp_one = fix_t'(v);
	endfunction

	function automatic fix_t to_frac(input cval_t v);
		cval_t r;
		r = (v + (cval_t'(1) <<< (CordicSteps - FracBits - 1))) >>> (CordicSteps - FracBits);
		to_frac = clamp_one(r);
	endfunction

	function automatic fix_t fmul(input fix_t a, input fix_t b);
		prod_t p;
		p = (prod_t'(a) * prod_t'(b) + (prod_t'(1) <<< (FracBits - 1))) >>> FracBits;
		fmul = fix_t'(p);
	endfunction

	function automatic fix_t sat_sum(input fix_t a, input fix_t b);
		cval_t s;
		s = cval_t'(a) + cval_t'(b);
		sat_sum = clamp_one(s);
	endfunction

endpackage

// File: rtl/core/ezrm_sincos.sv
// pipelined cordic sine and cosine of one binary angle, one step per stage
// depends on ezrm_pkg
module ezrm_sincos (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [ezrm_pkg::AngleBits-1:0] angle,
	output logic out_valid,
	output ezrm_pkg::fix_t cos_v,
	output ezrm_pkg::fix_t sin_v
);
	localparam int N = ezrm_pkg::CordicSteps;

	ezrm_pkg::cordic_t st_s1 [N+1];
	logic vld_s1 [N+1];
	ezrm_pkg::cordic_t nxt [N];
	logic [31:0] ph;
	logic flip;

	always_comb begin
		ph = {angle, {(32 - ezrm_pkg::AngleBits){1'b0}}};
		flip = (ph >= 32'h4000_0000) && (ph < 32'hC000_0000);
		if (flip)
			ph = ph - 32'h8000_0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1[0] <= 1'b0;
		end else begin
			vld_s1[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		st_s1[0].x <= ezrm_pkg::GainInit;
		st_s1[0].y <= '0;
		st_s1[0].z <= ezrm_pkg::phase_t'(signed'(ph));
		st_s1[0].flip <= flip;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_comb begin
			nxt[i] = st_s1[i];
			if (!st_s1[i].z[ezrm_pkg::PhaseW-1]) begin
				nxt[i].x = st_s1[i].x - (st_s1[i].y >>> i);
				nxt[i].y = st_s1[i].y + (st_s1[i].x >>> i);
				nxt[i].z = st_s1[i].z - ezrm_pkg::arc(i);
			end else begin
				nxt[i].x = st_s1[i].x + (st_s1[i].y >>> i);
				nxt[i].y = st_s1[i].y - (st_s1[i].x >>> i);
				nxt[i].z = st_s1[i].z + ezrm_pkg::arc(i);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[i+1] <= 1'b0;
			end else begin
				vld_s1[i+1] <= vld_s1[i];
			end
		end
		always_ff @(posedge clk) begin
			st_s1[i+1] <= nxt[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s1[N];
		end
	end

	always_ff @(posedge clk) begin
		if (st_s1[N].flip) begin
			cos_v <= ezrm_pkg::to_frac(-st_s1[N].x);
			sin_v <= ezrm_pkg::to_frac(-st_s1[N].y);
		end else begin
			cos_v <= ezrm_pkg::to_frac(st_s1[N].x);
			sin_v <= ezrm_pkg::to_frac(st_s1[N].y);
		end
	end
endmodule

// File: rtl/core/euler_xyz_to_rotation_matrix_core.sv
// top level: three cordic pipelines, then product stages for the xyz rotation matrix
// depends on ezrm_pkg and ezrm_sincos
//
// channel  | ports                                  | handshake
// input    | roll_angle, pitch_angle, yaw_angle     | start high, busy low
// result   | entry_r0c0 .. entry_r2c2               | done strobe, one cycle
//
// one beat per cycle; pipeline of 31 cordic stages, rounding, 3 product stages
// busy is held low: the pipeline never stalls since the receiver cannot hold off
// arst_n clears the valid bits only
module euler_xyz_to_rotation_matrix_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	output logic done,
	output logic signed [17:0] entry_r0c0,
	output logic signed [17:0] entry_r0c1,
	output logic signed [17:0] entry_r0c2,
	output logic signed [17:0] entry_r1c0,
	output logic signed [17:0] entry_r1c1,
	output logic signed [17:0] entry_r1c2,
	output logic signed [17:0] entry_r2c0,
	output logic signed [17:0] entry_r2c1,
	output logic signed [17:0] entry_r2c2
);
	ezrm_pkg::fix_t cx, sx, cy, sy, cz, sz;
	logic vx, vy, vz;
	logic go;

	assign busy = 1'b0;
	assign go = start && !busy;

	ezrm_sincos u_x (.clk, .arst_n, .in_valid(go), .angle(roll_angle),
		.out_valid(vx), .cos_v(cx), .sin_v(sx));
	ezrm_sincos u_y (.clk, .arst_n, .in_valid(go), .angle(pitch_angle),
		.out_valid(vy), .cos_v(cy), .sin_v(sy));
	ezrm_sincos u_z (.clk, .arst_n, .in_valid(go), .angle(yaw_angle),
		.out_valid(vz), .cos_v(cz), .sin_v(sz));

	// stage a: pair products
	ezrm_pkg::fix_t sxsy_s1, cxsy_s1, cycz_s1, cysz_s1, cxsz_s1, cxcz_s1;
	ezrm_pkg::fix_t sxcy_s1, sxsz_s1, sxcz_s1, cxcy_s1, sy_s1, cz_s1, sz_s1;
	logic v_s1, v_s2, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= vx && vy && vz;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sxsy_s1 <= ezrm_pkg::fmul(sx, sy);
		cxsy_s1 <= ezrm_pkg::fmul(cx, sy);
		cycz_s1 <= ezrm_pkg::fmul(cy, cz);
		cysz_s1 <= ezrm_pkg::fmul(cy, sz);
		cxsz_s1 <= ezrm_pkg::fmul(cx, sz);
		cxcz_s1 <= ezrm_pkg::fmul(cx, cz);
		sxcy_s1 <= ezrm_pkg::fmul(sx, cy);
		sxsz_s1 <= ezrm_pkg::fmul(sx, sz);
		sxcz_s1 <= ezrm_pkg::fmul(sx, cz);
		cxcy_s1 <= ezrm_pkg::fmul(cx, cy);
		sy_s1 <= sy;
		cz_s1 <= cz;
		sz_s1 <= sz;
	end

	// stage b: triple products
	ezrm_pkg::fix_t t10_s2, t11_s2, t20_s2, t21_s2;
	ezrm_pkg::fix_t a00_s2, a01_s2, a02_s2, a10_s2, a11_s2, a12_s2;
	ezrm_pkg::fix_t a20_s2, a21_s2, a22_s2;

	always_ff @(posedge clk) begin
		t10_s2 <= ezrm_pkg::fmul(sxsy_s1, cz_s1);
		t11_s2 <= ezrm_pkg::fmul(sxsy_s1, sz_s1);
		t20_s2 <= ezrm_pkg::fmul(cxsy_s1, cz_s1);
		t21_s2 <= ezrm_pkg::fmul(cxsy_s1, sz_s1);
		a00_s2 <= cycz_s1;
		a01_s2 <= cysz_s1;
		a02_s2 <= sy_s1;
		a10_s2 <= cxsz_s1;
		a11_s2 <= cxcz_s1;
		a12_s2 <= sxcy_s1;
		a20_s2 <= sxsz_s1;
		a21_s2 <= sxcz_s1;
		a22_s2 <= cxcy_s1;
	end

	// stage c: sums and saturation
	always_ff @(posedge clk) begin
		entry_r0c0 <= ezrm_pkg::sat_sum(a00_s2, '0);
		entry_r0c1 <= ezrm_pkg::sat_sum(-a01_s2, '0);
		entry_r0c2 <= ezrm_pkg::sat_sum(a02_s2, '0);
		entry_r1c0 <= ezrm_pkg::sat_sum(a10_s2, t10_s2);
		entry_r1c1 <= ezrm_pkg::sat_sum(a11_s2, -t11_s2);
		entry_r1c2 <= ezrm_pkg::sat_sum(-a12_s2, '0);
		entry_r2c0 <= ezrm_pkg::sat_sum(a20_s2, -t20_s2);
		entry_r2c1 <= ezrm_pkg::sat_sum(a21_s2, t21_s2);
		entry_r2c2 <= ezrm_pkg::sat_sum(a22_s2, '0);
	end

	assign done = v_s3;
endmodule

// File: bench/euler_xyz_to_rotation_matrix_core_tb.sv
// self-checking bench for the euler xyz to rotation matrix core: directed table, then random beats
// depends on ezrm_pkg and euler_xyz_to_rotation_matrix_core
module euler_xyz_to_rotation_matrix_core_tb;

	localparam int Latency = 35;
	localparam int CycleLimit = 200000;
	localparam int RandomBeats = 1200;
	localparam int TableRows = 16;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
	} angles_t;

	typedef struct packed {
		ezrm_pkg::fix_t r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2;
	} matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] roll_angle = '0;
	logic signed [15:0] pitch_angle = '0;
	logic signed [15:0] yaw_angle = '0;
	logic done;
	logic signed [17:0] entry_r0c0, entry_r0c1, entry_r0c2, entry_r1c0, entry_r1c1;
	logic signed [17:0] entry_r1c2, entry_r2c0, entry_r2c1, entry_r2c2;

	matrix_t expected_matrices[$];
	int mismatches = 0;
	int cycles = 0;

	angles_t stim_table[TableRows];
	matrix_t known_rows[TableRows];
	bit known_valid[TableRows];

	euler_xyz_to_rotation_matrix_core dut (.*);

	always #5 clk = ~clk;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unit_clamp(longint v);
		longint one;
		one = longint'(1) << 16;
		if (v > one)
			return one;
		if (v < -one)
			return -one;
		return v;
	endfunction

	function automatic longint phase_arc(int i);
		longint arcs[30];
		arcs = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1};
		return arcs[i];
	endfunction

	function automatic void angle_sin_cos(input logic [15:0] angle, output longint c,
		output longint s);
		logic [31:0] ph;
		bit flip;
		longint x, y, z, dx, dy;
		ph = {angle, 16'h0};
		flip = 1'b0;
		x = 652032874;
		y = 0;
		if (ph >= 32'h4000_0000 && ph < 32'hC000_0000) begin
			ph = ph - 32'h8000_0000;
			flip = 1'b1;
		end
		z = longint'($signed(ph));
		for (int i = 0; i < 30; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= phase_arc(i);
			end else begin
				x += dx; y -= dy; z += phase_arc(i);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = unit_clamp(floor_shift(x + (longint'(1) << 13), 14));
		s = unit_clamp(floor_shift(y + (longint'(1) << 13), 14));
	endfunction

	function automatic longint fix_mul(longint a, longint b);
		return floor_shift(a * b + (longint'(1) << 15), 16);
	endfunction

	function automatic matrix_t rotation_of(angles_t a);
		longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
		matrix_t m;
		angle_sin_cos(a.roll, cx, sx);
		angle_sin_cos(a.pitch, cy, sy);
		angle_sin_cos(a.yaw, cz, sz);
		sxsy = fix_mul(sx, sy);
		cxsy = fix_mul(cx, sy);
		m.r0c0 = ezrm_pkg::fix_t'(unit_clamp(fix_mul(cy, cz)));
		m.r0c1 = ezrm_pkg::fix_t'(unit_clamp(-fix_mul(cy, sz)));
		m.r0c2 = ezrm_pkg::fix_t'(unit_clamp(sy));
		m.r1c0 = ezrm_pkg::fix_t'(unit_clamp(fix_mul(cx, sz) + fix_mul(sxsy, cz)));
		m.r1c1 = ezrm_pkg::fix_t'(unit_clamp(fix_mul(cx, cz) - fix_mul(sxsy, sz)));
		m.r1c2 = ezrm_pkg::fix_t'(unit_clamp(-fix_mul(sx, cy)));
		m.r2c0 = ezrm_pkg::fix_t'(unit_clamp(fix_mul(sx, sz) - fix_mul(cxsy, cz)));
		m.r2c1 = ezrm_pkg::fix_t'(unit_clamp(fix_mul(sx, cz) + fix_mul(cxsy, sz)));
		m.r2c2 = ezrm_pkg::fix_t'(unit_clamp(fix_mul(cx, cy)));
		return m;
	endfunction

	// result side: check each strobed beat against the oldest expectation
	always @(posedge clk) begin
		matrix_t got, want;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			got = {entry_r0c0, entry_r0c1, entry_r0c2, entry_r1c0, entry_r1c1,
				entry_r1c2, entry_r2c0, entry_r2c1, entry_r2c2};
			if (expected_matrices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", got);
			end else begin
				want = expected_matrices.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_beat(input angles_t a, input bit has_known, input matrix_t known);
		roll_angle <= a.roll;
		pitch_angle <= a.pitch;
		yaw_angle <= a.yaw;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_matrices.push_back(has_known ? known : rotation_of(a));
	endtask

	task automatic idle_burst(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic build_table;
		int n;
		angles_t corners[12];
		corners = '{'{16'sh0000, 16'sh0000, 16'sh0000}, '{16'sh4000, 16'sh0000, 16'sh0000},
			'{16'sh0000, 16'sh4000, 16'sh0000}, '{16'sh0000, 16'sh0000, 16'sh4000},
			'{16'sh8000, 16'sh8000, 16'sh8000}, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
			'{16'shC000, 16'shC000, 16'shC000}, '{16'sh3FFF, 16'shBFFF, 16'sh4001},
			'{16'shFFFF, 16'sh0001, 16'shFFFF}, '{16'sh2000, 16'sh2000, 16'sh2000},
			'{16'sh5555, 16'shAAAA, 16'sh1234}, '{16'shE000, 16'sh6000, 16'shA000}};
		for (n = 0; n < TableRows; n++) begin
			stim_table[n] = n < 12 ? corners[n] : angles_t'({16'(n * 4096), 16'(-n), 16'(n)});
			known_valid[n] = 1'b0;
		end
		// zero angles give the identity
		known_rows[0] = '{18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0,
			18'sd0, 18'sd0, 18'sd65536};
		known_valid[0] = 1'b1;
	endtask

	initial begin
		angles_t a;
		build_table();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int n = 0; n < TableRows; n++) begin
			send_beat(stim_table[n], known_valid[n], known_rows[n]);
			if (n % 5 == 4)
				idle_burst($urandom_range(1, 8));
		end
		for (int n = 0; n < RandomBeats; n++) begin
			a = {16'($urandom), 16'($urandom), 16'($urandom)};
			if ($urandom_range(0, 7) == 0)
				a.pitch = 16'($urandom_range(0, 3) << 14);
			send_beat(a, 1'b0, '0);
			if (n == RandomBeats / 2) begin
				start <= 1'b0;
				while (expected_matrices.size() != 0)
					@(posedge clk);
			end else if (n < RandomBeats - 200 && $urandom_range(0, 3) == 0) begin
				idle_burst($urandom_range(1, 8));
			end
		end
		start <= 1'b0;
		while (expected_matrices.size() != 0)
			@(posedge clk);
		repeat (Latency + 5) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
